FILE: rtl/mcpt_pkg.sv
// mcpt_pkg: shared constants, opcodes and types of the periodic timer
// used by mcpt_ctrl, mcpt_datapath and multi_channel_periodic_timer
package mcpt_pkg;

  localparam int NumChannels = 16;
  localparam int ChanW       = 4;
  localparam int CntW        = ChanW + 1;
  localparam int TickMs      = 10;

  // reciprocal for the divide by the tick period, one correction step after it
  localparam int          TickL      = $clog2(TickMs);
  localparam int          RecipShift = 31 + TickL;
  localparam logic [31:0] Recip      = 32'((64'd1 << RecipShift) / TickMs);
  localparam logic [31:0] TickMsW    = 32'(TickMs);

  localparam logic [2:0] OpTick       = 3'd0;
  localparam logic [2:0] OpRegister   = 3'd1;
  localparam logic [2:0] OpRelease    = 3'd2;
  localparam logic [2:0] OpStart      = 3'd3;
  localparam logic [2:0] OpStop       = 3'd4;
  localparam logic [2:0] OpSetTimeout = 3'd5;

  localparam logic KindStatus = 1'b0;
  localparam logic KindExpiry = 1'b1;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [ChanW-1:0] channel;
    logic [31:0]      timeout_ms;
  } cmd_t;

  typedef struct packed {
    logic             kind;
    logic             ok;
    logic [ChanW-1:0] result_channel;
    logic             last;
  } res_t;

  typedef struct packed {
    logic load_in;
    logic tick_inc;
    logic idx_clear;
    logic idx_load_ch;
    logic idx_inc;
    logic rd_next;
    logic do_register;
    logic do_start;
    logic do_stop;
    logic do_settmo;
    logic do_shift;
    logic do_clear_top;
    logic scan_fire;
    logic push_resp;
    logic push_pend;
    logic pend_last;
    logic resp_load;
    logic resp_ok;
    logic resp_reg;
  } ctl_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       full;
    logic       ch_lt_used;
    logic       tmo_ok;
    logic       shift_more;
    logic       scan_more;
    logic       due;
    logic       pend_valid;
    logic       out_free;
  } stat_t;

endpackage

FILE: rtl/mcpt_datapath.sv
// mcpt_datapath: channel table, tick counter, timeout divider and result register
// depends on mcpt_pkg; steered by mcpt_ctrl through ctl_t and stat_t
module mcpt_datapath (
  input  logic              clk,
  input  logic              rst,
  input  mcpt_pkg::cmd_t    cmd,
  input  mcpt_pkg::ctl_t    ctl,
  output mcpt_pkg::stat_t   stat,
  output logic              res_valid,
  input  logic              res_ready,
  output mcpt_pkg::res_t    res
);

  mcpt_pkg::cmd_t cmd_r;

  logic [31:0]                    tick_count;
  logic [mcpt_pkg::CntW-1:0]      used;
  logic [mcpt_pkg::CntW-1:0]      idx;
  logic [mcpt_pkg::NumChannels-1:0] armed;

  logic [31:0] period_mem [mcpt_pkg::NumChannels];
  logic [31:0] stamp_mem  [mcpt_pkg::NumChannels];
  logic [31:0] period_rd;
  logic [31:0] stamp_rd;

  logic [63:0] prod;
  logic [31:0] qd;
  logic [31:0] rem0;
  logic [31:0] q_est;
  logic        fix;
  logic [31:0] quot;
  logic        tmo_ok;

  logic                       pend_valid;
  logic [mcpt_pkg::ChanW-1:0] pend_ch;
  logic                       resp_ok;
  logic [mcpt_pkg::ChanW-1:0] resp_ch;

  logic [mcpt_pkg::ChanW-1:0] rd_addr;
  logic [mcpt_pkg::ChanW-1:0] cur;
  logic [mcpt_pkg::ChanW-1:0] top;
  logic [mcpt_pkg::CntW-1:0]  idx_inc1;
  logic                       due;
  logic                       out_free;

  logic                       p_we;
  logic [mcpt_pkg::ChanW-1:0] p_wa;
  logic [31:0]                p_wd;
  logic                       s_we;
  logic [mcpt_pkg::ChanW-1:0] s_wa;
  logic [31:0]                s_wd;

  assign cur      = idx[mcpt_pkg::ChanW-1:0];
  assign idx_inc1 = idx + mcpt_pkg::CntW'(1);
  assign top      = mcpt_pkg::ChanW'(used - mcpt_pkg::CntW'(1));
  assign rd_addr  = ctl.rd_next ? mcpt_pkg::ChanW'(cur + mcpt_pkg::ChanW'(1)) : cur;

  // divide by the tick period
  assign q_est  = 32'(prod >> mcpt_pkg::RecipShift);
  assign fix    = rem0 >= mcpt_pkg::TickMsW;
  assign quot   = q_est + {31'd0, fix};
  assign tmo_ok = (cmd_r.timeout_ms != 32'd0) &&
                  (fix ? (rem0 == mcpt_pkg::TickMsW) : (rem0 == 32'd0));

  always_ff @(posedge clk) begin
    prod <= 64'(cmd_r.timeout_ms) * 64'(mcpt_pkg::Recip);
    qd   <= 32'(q_est * mcpt_pkg::TickMsW);
    rem0 <= cmd_r.timeout_ms - qd;
  end

  assign due      = armed[cur] && ((tick_count - stamp_rd) > period_rd);
  assign out_free = !res_valid || res_ready;

  always_comb begin
    stat.opcode     = cmd_r.opcode;
    stat.full       = used == mcpt_pkg::CntW'(mcpt_pkg::NumChannels);
    stat.ch_lt_used = {1'b0, cmd_r.channel} < used;
    stat.tmo_ok     = tmo_ok;
    stat.shift_more = idx_inc1 < used;
    stat.scan_more  = idx < used;
    stat.due        = due;
    stat.pend_valid = pend_valid;
    stat.out_free   = out_free;
  end

  // period write port
  always_comb begin
    p_we = 1'b1;
    p_wa = cur;
    p_wd = 32'd0;
    priority if (ctl.do_register) begin
      p_wa = used[mcpt_pkg::ChanW-1:0];
      p_wd = quot;
    end else if (ctl.do_settmo) begin
      p_wa = cmd_r.channel;
      p_wd = quot;
    end else if (ctl.do_shift) begin
      p_wa = cur;
      p_wd = period_rd;
    end else if (ctl.do_clear_top) begin
      p_wa = top;
    end else begin
      p_we = 1'b0;
    end
  end

  // stamp write port
  always_comb begin
    s_we = 1'b1;
    s_wa = cur;
    s_wd = 32'd0;
    priority if (ctl.do_register) begin
      s_wa = used[mcpt_pkg::ChanW-1:0];
    end else if (ctl.do_start) begin
      s_wa = cmd_r.channel;
      s_wd = tick_count;
    end else if (ctl.do_shift) begin
      s_wa = cur;
      s_wd = stamp_rd;
    end else if (ctl.do_clear_top) begin
      s_wa = top;
    end else if (ctl.scan_fire) begin
      s_wa = cur;
      s_wd = tick_count;
    end else begin
      s_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      period_mem[p_wa] <= p_wd;
    end
    if (s_we) begin
      stamp_mem[s_wa] <= s_wd;
    end
    period_rd <= period_mem[rd_addr];
    stamp_rd  <= stamp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_r <= cmd;
    end
    if (ctl.resp_load) begin
      resp_ok <= ctl.resp_ok;
      resp_ch <= ctl.resp_reg ? used[mcpt_pkg::ChanW-1:0] : '0;
    end
    if (ctl.scan_fire) begin
      pend_ch <= cur;
    end
    if (ctl.push_resp) begin
      res <= '{kind: mcpt_pkg::KindStatus, ok: resp_ok, result_channel: resp_ch,
               last: 1'b1};
    end else if (ctl.push_pend) begin
      res <= '{kind: mcpt_pkg::KindExpiry, ok: 1'b1, result_channel: pend_ch,
               last: ctl.pend_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      used       <= '0;
      idx        <= '0;
      armed      <= '0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (ctl.tick_inc) begin
        tick_count <= tick_count + 32'd1;
      end
      if (ctl.do_register) begin
        used <= used + mcpt_pkg::CntW'(1);
      end else if (ctl.do_clear_top) begin
        used <= used - mcpt_pkg::CntW'(1);
      end
      if (ctl.idx_clear) begin
        idx <= '0;
      end else if (ctl.idx_load_ch) begin
        idx <= {1'b0, cmd_r.channel};
      end else if (ctl.idx_inc) begin
        idx <= idx_inc1;
      end
      if (ctl.do_register) begin
        armed[used[mcpt_pkg::ChanW-1:0]] <= 1'b0;
      end else if (ctl.do_start) begin
        armed[cmd_r.channel] <= 1'b1;
      end else if (ctl.do_stop || ctl.do_settmo) begin
        armed[cmd_r.channel] <= 1'b0;
      end else if (ctl.do_shift) begin
        armed[cur] <= armed[mcpt_pkg::ChanW'(cur + mcpt_pkg::ChanW'(1))];
      end else if (ctl.do_clear_top) begin
        armed[top] <= 1'b0;
      end
      if (ctl.tick_inc) begin
        pend_valid <= 1'b0;
      end else if (ctl.scan_fire) begin
        pend_valid <= 1'b1;
      end else if (ctl.push_pend) begin
        pend_valid <= 1'b0;
      end
      if (ctl.push_resp || ctl.push_pend) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.push_resp || ctl.push_pend) |-> (!res_valid || res_ready))
    else $error("result pushed over an unread beat");
  a_reg_room: assert property (@(posedge clk) disable iff (rst)
    ctl.do_register |-> (used < mcpt_pkg::CntW'(mcpt_pkg::NumChannels)))
    else $error("register into a full table");
  a_reg_count: assert property (@(posedge clk) disable iff (rst)
    ctl.do_register |=> (used == mcpt_pkg::CntW'($past(used) + mcpt_pkg::CntW'(1))))
    else $error("used count did not advance on register");
  a_clear_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.do_clear_top |-> (used != '0))
    else $error("release on an empty table");
  a_fire_due: assert property (@(posedge clk) disable iff (rst)
    ctl.scan_fire |-> (due && stat.scan_more))
    else $error("expiry on a channel that is not due");
`endif

endmodule

FILE: rtl/mcpt_ctrl.sv
// mcpt_ctrl: sequencer for commands, release shifts and the tick scan
// depends on mcpt_pkg; drives mcpt_datapath through ctl_t
module mcpt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  mcpt_pkg::stat_t stat,
  output mcpt_pkg::ctl_t  ctl
);

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StDiv1    = 4'd1;
  localparam logic [3:0] StDiv2    = 4'd2;
  localparam logic [3:0] StDiv3    = 4'd3;
  localparam logic [3:0] StExec    = 4'd4;
  localparam logic [3:0] StRelRd   = 4'd5;
  localparam logic [3:0] StRelWr   = 4'd6;
  localparam logic [3:0] StRelClr  = 4'd7;
  localparam logic [3:0] StScanRd  = 4'd8;
  localparam logic [3:0] StScanEv  = 4'd9;
  localparam logic [3:0] StScanEnd = 4'd10;
  localparam logic [3:0] StResp    = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign cmd_ready = state == StIdle;

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      StIdle: begin
        if (cmd_valid) begin
          ctl.load_in = 1'b1;
          state_next  = StDiv1;
        end
      end
      StDiv1: state_next = StDiv2;
      StDiv2: state_next = StDiv3;
      StDiv3: state_next = StExec;
      StExec: begin
        ctl.resp_load = 1'b1;
        state_next    = StResp;
        unique case (stat.opcode)
          mcpt_pkg::OpTick: begin
            ctl.resp_load = 1'b0;
            ctl.tick_inc  = 1'b1;
            ctl.idx_clear = 1'b1;
            state_next    = StScanRd;
          end
          mcpt_pkg::OpRegister: begin
            ctl.do_register = stat.tmo_ok && !stat.full;
            ctl.resp_ok     = stat.tmo_ok && !stat.full;
            ctl.resp_reg    = stat.tmo_ok && !stat.full;
          end
          mcpt_pkg::OpRelease: begin
            if (stat.ch_lt_used) begin
              ctl.resp_ok     = 1'b1;
              ctl.idx_load_ch = 1'b1;
              state_next      = StRelRd;
            end
          end
          mcpt_pkg::OpStart: begin
            ctl.do_start = 1'b1;
            ctl.resp_ok  = 1'b1;
          end
          mcpt_pkg::OpStop: begin
            ctl.do_stop = 1'b1;
            ctl.resp_ok = 1'b1;
          end
          mcpt_pkg::OpSetTimeout: begin
            ctl.do_settmo = stat.tmo_ok;
            ctl.resp_ok   = stat.tmo_ok;
          end
          default: begin
            ctl.resp_ok = 1'b0;
          end
        endcase
      end
      StRelRd: begin
        if (stat.shift_more) begin
          ctl.rd_next = 1'b1;
          state_next  = StRelWr;
        end else begin
          state_next = StRelClr;
        end
      end
      StRelWr: begin
        ctl.do_shift = 1'b1;
        ctl.idx_inc  = 1'b1;
        state_next   = StRelRd;
      end
      StRelClr: begin
        ctl.do_clear_top = 1'b1;
        state_next       = StResp;
      end
      StScanRd: begin
        if (stat.scan_more) begin
          state_next = StScanEv;
        end else if (stat.pend_valid) begin
          state_next = StScanEnd;
        end else begin
          state_next = StIdle;
        end
      end
      StScanEv: begin
        if (!stat.due) begin
          ctl.idx_inc = 1'b1;
          state_next  = StScanRd;
        end else if (!stat.pend_valid || stat.out_free) begin
          ctl.push_pend = stat.pend_valid;
          ctl.scan_fire = 1'b1;
          ctl.idx_inc   = 1'b1;
          state_next    = StScanRd;
        end
      end
      StScanEnd: begin
        if (stat.out_free) begin
          ctl.push_pend = 1'b1;
          ctl.pend_last = 1'b1;
          state_next    = StIdle;
        end
      end
      StResp: begin
        if (stat.out_free) begin
          ctl.push_resp = 1'b1;
          state_next    = StIdle;
        end
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/multi_channel_periodic_timer.sv
// multi_channel_periodic_timer: top level of the periodic timer table
// depends on mcpt_pkg, mcpt_ctrl and mcpt_datapath
//
// cmd channel: one beat per command (tick, register, release, start, stop,
// set timeout); res channel: status and expiry beats, last marks the final
// beat caused by a command
// a non-tick command gives one status beat after it passes the divider states,
// StExec and StResp; release adds StRelRd and StRelWr per shifted channel and
// StRelRd and StRelClr for last check and top slot; a tick walks StScanRd and
// StScanEv per used channel, then StScanEnd if any is due; each expiry beat is
// held one channel back so that last marks the final one; no beat if none is due
// the next command is taken as soon as the previous one finishes, while its
// last beat may still sit in the output register
// divider (reciprocal multiply and correction) runs in StDiv1, StDiv2 and StDiv3;
// the table has one read port, so the scan and release walk one slot at a time
// reset clears the tick counter, the used count and all armed bits; the
// table holds no data until a slot is registered
// when res_ready is low the sequencer waits with the next beat and takes
// no new command until it has been placed
module multi_channel_periodic_timer (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  mcpt_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output mcpt_pkg::res_t res
);

  mcpt_pkg::ctl_t  ctl;
  mcpt_pkg::stat_t stat;

  mcpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  mcpt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .stat      (stat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

FILE: bench/mcpt_checker.sv
`timescale 1ns / 1ps
// mcpt_checker: watches the cmd and res channels of the periodic timer, predicts
// every result beat from its own copy of the channel table and compares them
// depends on mcpt_pkg for the beat types, opcodes and table size
module mcpt_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  logic           cmd_ready,
  input  mcpt_pkg::cmd_t cmd,
  input  logic           res_valid,
  input  logic           res_ready,
  input  mcpt_pkg::res_t res,
  output int             errors,
  output int             pending,
  output int             beats,
  output int             expiries,
  output int             max_burst
);

  logic [31:0]    tick_now;
  int             slots_used;
  logic [31:0]    slot_period [mcpt_pkg::NumChannels];
  logic [31:0]    slot_stamp  [mcpt_pkg::NumChannels];
  logic           slot_armed  [mcpt_pkg::NumChannels];
  mcpt_pkg::res_t expected_beats [$];

  function automatic logic timeout_ok(input logic [31:0] t);
    return t != 32'd0 && (t % 32'(mcpt_pkg::TickMs)) == 32'd0;
  endfunction

  task automatic clear_table();
    tick_now   = '0;
    slots_used = 0;
    for (int i = 0; i < mcpt_pkg::NumChannels; i++) begin
      slot_period[i] = '0;
      slot_stamp[i]  = '0;
      slot_armed[i]  = 1'b0;
    end
    expected_beats.delete();
  endtask

  task automatic predict(input mcpt_pkg::cmd_t c);
    mcpt_pkg::res_t r;
    int             due [$];
    logic [31:0]    elapsed;
    r                = '0;
    r.kind           = mcpt_pkg::KindStatus;
    r.last           = 1'b1;
    case (c.opcode)
      mcpt_pkg::OpTick: begin
        tick_now = tick_now + 32'd1;
        for (int i = 0; i < slots_used; i++) begin
          elapsed = tick_now - slot_stamp[i];
          if (slot_armed[i] && elapsed > slot_period[i] &&
              due.size() < mcpt_pkg::NumChannels) begin
            due.push_back(i);
            slot_stamp[i] = tick_now;
          end
        end
        for (int k = 0; k < due.size(); k++) begin
          r.kind           = mcpt_pkg::KindExpiry;
          r.ok             = 1'b1;
          r.result_channel = due[k][mcpt_pkg::ChanW-1:0];
          r.last           = (k == due.size() - 1);
          expected_beats.push_back(r);
        end
        if (due.size() > max_burst) max_burst = due.size();
      end
      mcpt_pkg::OpRegister: begin
        if (timeout_ok(c.timeout_ms) && slots_used < mcpt_pkg::NumChannels) begin
          slot_period[slots_used] = c.timeout_ms / 32'(mcpt_pkg::TickMs);
          slot_stamp[slots_used]  = '0;
          slot_armed[slots_used]  = 1'b0;
          r.ok                    = 1'b1;
          r.result_channel        = slots_used[mcpt_pkg::ChanW-1:0];
          slots_used++;
        end
      end
      mcpt_pkg::OpRelease: begin
        if (int'(c.channel) < slots_used) begin
          for (int i = int'(c.channel); i + 1 < slots_used; i++) begin
            slot_period[i] = slot_period[i+1];
            slot_stamp[i]  = slot_stamp[i+1];
            slot_armed[i]  = slot_armed[i+1];
          end
          slots_used--;
          slot_period[slots_used] = '0;
          slot_stamp[slots_used]  = '0;
          slot_armed[slots_used]  = 1'b0;
          r.ok = 1'b1;
        end
      end
      mcpt_pkg::OpStart: begin
        slot_stamp[c.channel] = tick_now;
        slot_armed[c.channel] = 1'b1;
        r.ok = 1'b1;
      end
      mcpt_pkg::OpStop: begin
        slot_armed[c.channel] = 1'b0;
        r.ok = 1'b1;
      end
      mcpt_pkg::OpSetTimeout: begin
        if (timeout_ok(c.timeout_ms)) begin
          slot_armed[c.channel]  = 1'b0;
          slot_period[c.channel] = c.timeout_ms / 32'(mcpt_pkg::TickMs);
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    if (c.opcode != mcpt_pkg::OpTick) expected_beats.push_back(r);
  endtask

  task automatic check_beat(input mcpt_pkg::res_t got);
    mcpt_pkg::res_t want;
    if (expected_beats.size() == 0) begin
      $error("unexpected beat: kind %0d ok %0d result_channel %0d last %0d",
             got.kind, got.ok, got.result_channel, got.last);
      errors++;
    end else begin
      want = expected_beats.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.ok !== want.ok) begin
        $error("ok: expected %0d, got %0d", want.ok, got.ok);
        errors++;
      end
      if (got.result_channel !== want.result_channel) begin
        $error("result_channel: expected %0d, got %0d", want.result_channel,
               got.result_channel);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
      beats++;
      if (want.kind == mcpt_pkg::KindExpiry) expiries++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_table();
      errors    = 0;
      beats     = 0;
      expiries  = 0;
      max_burst = 0;
    end else begin
      if (res_valid && res_ready) check_beat(res);
      if (cmd_valid && cmd_ready) predict(cmd);
    end
    pending <= expected_beats.size();
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for multi_channel_periodic_timer
// depends on mcpt_pkg, the block itself and mcpt_checker
module tb_top;

  localparam logic [2:0] OpUndefLow  = 3'd6;
  localparam logic [2:0] OpUndefHigh = 3'd7;
  localparam int         RandomCmds  = 305;
  localparam int         CalmCmds    = 40;
  localparam int         SettleCycles = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  mcpt_pkg::cmd_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  mcpt_pkg::res_t res;

  int   errors;
  int   pending;
  int   beats;
  int   expiries;
  int   max_burst;
  int   sent = 0;
  bit   calm = 1'b0;
  int   hold_left = 0;

  always #5 clk = ~clk;

  multi_channel_periodic_timer DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  mcpt_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .errors    (errors),
    .pending   (pending),
    .beats     (beats),
    .expiries  (expiries),
    .max_burst (max_burst)
  );

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (rst || calm) begin
      res_ready <= 1'b1;
    end else if (hold_left > 0) begin
      res_ready <= 1'b0;
      hold_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      res_ready <= 1'b0;
      hold_left = $urandom_range(0, 4);
    end else begin
      res_ready <= 1'b1;
    end
  end

  function automatic mcpt_pkg::cmd_t pack_cmd(input logic [2:0] op, input logic [3:0] ch,
                                              input logic [31:0] tmo);
    mcpt_pkg::cmd_t c;
    c.opcode     = op;
    c.channel    = ch;
    c.timeout_ms = tmo;
    return c;
  endfunction

  function automatic logic [31:0] pick_timeout();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return 32'd0;
      2:       return ($urandom / 32'd10) * 32'd10;
      3:       return 32'(10 * $urandom_range(0, 50) + $urandom_range(1, 9));
      default: return 32'(10 * $urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [3:0] pick_channel();
    if ($urandom_range(0, 1) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, 5));
  endfunction

  task automatic send(input mcpt_pkg::cmd_t c);
    if (!calm && $urandom_range(0, 4) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    sent++;
  endtask

  // hold the sender until every predicted beat has been seen
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int directed;
    int storms;
    storms = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send(pack_cmd(mcpt_pkg::OpRelease, 4'd0, 32'd0));
    send(pack_cmd(mcpt_pkg::OpRegister, 4'd0, 32'd0));
    send(pack_cmd(mcpt_pkg::OpRegister, 4'd0, 32'd15));
    send(pack_cmd(mcpt_pkg::OpRegister, 4'd0, 32'hFFFF_FFFF));
    send(pack_cmd(mcpt_pkg::OpRegister, 4'd0, 32'd10));
    send(pack_cmd(mcpt_pkg::OpRegister, 4'd0, 32'd4294967290));
    send(pack_cmd(mcpt_pkg::OpRegister, 4'd0, 32'd20));
    send(pack_cmd(mcpt_pkg::OpStart, 4'd0, 32'd0));
    send(pack_cmd(mcpt_pkg::OpStart, 4'd2, 32'd0));
    send(pack_cmd(mcpt_pkg::OpStart, 4'd1, 32'd0));
    repeat (4) send(pack_cmd(mcpt_pkg::OpTick, 4'd0, 32'd0));
    send(pack_cmd(mcpt_pkg::OpStop, 4'd2, 32'd0));
    send(pack_cmd(mcpt_pkg::OpSetTimeout, 4'd1, 32'd7));
    send(pack_cmd(mcpt_pkg::OpSetTimeout, 4'd1, 32'd10));
    send(pack_cmd(mcpt_pkg::OpSetTimeout, 4'd15, 32'd50));
    send(pack_cmd(mcpt_pkg::OpStart, 4'd15, 32'hFFFF_FFFF));
    send(pack_cmd(OpUndefLow, 4'd3, 32'd10));
    send(pack_cmd(OpUndefHigh, 4'd15, 32'hFFFF_FFFF));
    send(pack_cmd(mcpt_pkg::OpRelease, 4'd15, 32'd0));
    send(pack_cmd(mcpt_pkg::OpRelease, 4'd0, 32'd0));
    send(pack_cmd(mcpt_pkg::OpTick, 4'd0, 32'd0));
    send(pack_cmd(mcpt_pkg::OpStop, 4'd15, 32'd0));
    directed = sent;
    drain();

    while (sent - directed < RandomCmds) begin
      calm = (RandomCmds - (sent - directed) <= CalmCmds);
      case ($urandom_range(0, 9))
        0: begin
          if (storms < 2) begin
            // fill the table, arm every slot and tick so that many of them fire together
            storms++;
            repeat (mcpt_pkg::NumChannels + 1)
              send(pack_cmd(mcpt_pkg::OpRegister, pick_channel(),
                            32'(10 * $urandom_range(1, 2))));
            for (int i = 0; i < mcpt_pkg::NumChannels; i++)
              send(pack_cmd(mcpt_pkg::OpStart, 4'(i), $urandom));
            repeat ($urandom_range(2, 4)) send(pack_cmd(mcpt_pkg::OpTick, 4'd0, $urandom));
            if (storms == 1) drain();
          end else begin
            send(pack_cmd(mcpt_pkg::OpTick, pick_channel(), $urandom));
          end
        end
        1, 2: begin
          repeat ($urandom_range(1, 3))
            send(pack_cmd(mcpt_pkg::OpRelease, pick_channel(), $urandom));
          repeat ($urandom_range(1, 3))
            send(pack_cmd(mcpt_pkg::OpRegister, pick_channel(), pick_timeout()));
        end
        3, 4: begin
          repeat ($urandom_range(1, 4))
            send(pack_cmd(($urandom_range(0, 3) == 0) ? mcpt_pkg::OpStop : mcpt_pkg::OpStart,
                          pick_channel(), $urandom));
        end
        5, 6, 7: begin
          repeat ($urandom_range(2, 6))
            send(pack_cmd(mcpt_pkg::OpTick, pick_channel(), $urandom));
        end
        8: begin
          repeat ($urandom_range(1, 4))
            send(pack_cmd(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                          pick_timeout()));
        end
        default: begin
          send(pack_cmd(mcpt_pkg::OpSetTimeout, pick_channel(), pick_timeout()));
          send(pack_cmd(mcpt_pkg::OpStart, pick_channel(), $urandom));
        end
      endcase
    end

    drain();
    repeat (SettleCycles) @(posedge clk);
    $display("tb_top: %0d commands sent, %0d result beats checked", sent, beats);
    $display("tb_top: %0d expiries seen, at most %0d on a single tick", expiries, max_burst);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: sim.f
rtl/mcpt_pkg.sv
rtl/mcpt_datapath.sv
rtl/mcpt_ctrl.sv
rtl/multi_channel_periodic_timer.sv
bench/mcpt_checker.sv
bench/tb_top.sv
